// ===== hdl/mdp_pkg.sv =====
// Shared types and constants for the MIDI stream parser.
// No dependencies; used by mdp_parse and the top level.
package mdp_pkg;

   localparam logic [7:0] STATUS_REALTIME = 8'hF8;
   localparam logic [7:0] STATUS_SOX      = 8'hF0;
   localparam logic [7:0] STATUS_EOX      = 8'hF7;
   localparam logic [3:0] CMD_NOTE_OFF    = 4'h8;
   localparam logic [3:0] CMD_NOTE_ON     = 4'h9;
   localparam logic [3:0] CMD_CONTROL     = 4'hB;
   localparam logic [3:0] CMD_PROGRAM     = 4'hC;
   localparam logic [3:0] CMD_PRESSURE    = 4'hD;
   localparam logic [3:0] CMD_BEND        = 4'hE;

   localparam int unsigned CODE_W  = 49;
   localparam int unsigned CSR_W   = 7;
   localparam int unsigned RSP_W   = 104;

   localparam logic [6:0] FAMILY_ID_RESET     = 7'h14;
   localparam logic [6:0] QUERY_COMMAND_RESET = 7'h00;

   typedef enum logic [0:0] {
      CSR_FAMILY_ID     = 1'b0,
      CSR_QUERY_COMMAND = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      KIND_NOTE_OFF   = 4'd0,
      KIND_NOTE_ON    = 4'd1,
      KIND_CONTROL    = 4'd2,
      KIND_PROGRAM    = 4'd3,
      KIND_PRESSURE   = 4'd4,
      KIND_BEND       = 4'd5,
      KIND_SYSEX_DATA = 4'd6,
      KIND_SYSEX_END  = 4'd7,
      KIND_ABORT      = 4'd8,
      KIND_CHALLENGE  = 4'd9
   } kind_type;

   typedef struct packed {
      logic [6:0] family_id;
      logic [6:0] query_command;
   } cfg_type;

   // Last member sits in the lowest bits, matching the rsp_tdata layout.
   typedef struct packed {
      logic              pad;
      logic [CODE_W-1:0] chal_code;
      logic              is_query;
      logic [8:0]        sysex_length;
      logic [7:0]        sysex_index;
      logic [13:0]       bend_value;
      logic [6:0]        data_two;
      logic [6:0]        data_one;
      logic [3:0]        channel;
      kind_type          kind;
   } result_type;

endpackage

// ===== hdl/mdp_parse.sv =====
// Parser state and the per-byte decode that produces at most one result.
// Depends on mdp_pkg.
module mdp_parse #(
   parameter int unsigned SYSEX_MAX       = 256,
   parameter int unsigned CHALLENGE_BYTES = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   input  mdp_pkg::cfg_type    cfg,
   output logic                emit,
   output mdp_pkg::result_type result
);

   localparam int unsigned BCW = $clog2(SYSEX_MAX + 1);
   localparam int unsigned CCW = $clog2(CHALLENGE_BYTES + 1);

   logic                       in_sysex_ff, in_sysex_in;
   logic [BCW-1:0]             byte_count_ff, byte_count_in;
   logic [7:0]                 running_ff, running_in;
   logic [6:0]                 held_ff, held_in;
   logic [6:0]                 seen_family_ff, seen_family_in;
   logic [6:0]                 seen_command_ff, seen_command_in;
   logic                       awaiting_ff, awaiting_in;
   logic [CCW-1:0]             chal_count_ff, chal_count_in;
   logic [mdp_pkg::CODE_W-1:0] chal_shift_ff, chal_shift_in;
   logic [BCW+8:0]             count_wide;
   logic                       query_hit;

   assign count_wide = {9'd0, byte_count_ff};
   assign query_hit  = (byte_count_ff == BCW'(5))
                    && (seen_family_ff == cfg.family_id)
                    && (seen_command_ff == cfg.query_command);

   always_comb begin
      in_sysex_in     = in_sysex_ff;
      byte_count_in   = byte_count_ff;
      running_in      = running_ff;
      held_in         = held_ff;
      seen_family_in  = seen_family_ff;
      seen_command_in = seen_command_ff;
      awaiting_in     = awaiting_ff;
      chal_count_in   = chal_count_ff;
      chal_shift_in   = chal_shift_ff;
      emit            = 1'b0;
      result          = '0;

      if (rx_byte < mdp_pkg::STATUS_REALTIME) begin
         // any status other than EOX ends an open SysEx
         if (in_sysex_ff && rx_byte[7] && rx_byte != mdp_pkg::STATUS_EOX) begin
            emit                = 1'b1;
            result.kind         = mdp_pkg::KIND_ABORT;
            result.sysex_length = count_wide[8:0];
            in_sysex_in         = 1'b0;
            byte_count_in       = '0;
         end

         if (awaiting_ff && !rx_byte[7]) begin
            // slots past the code width are dropped
            for (int i = 0; i < 7; i++) begin
               if (int'(chal_count_ff) == i) begin
                  chal_shift_in[7*i +: 7] = chal_shift_ff[7*i +: 7] | rx_byte[6:0];
               end
            end
            chal_count_in = chal_count_ff + CCW'(1);
            if (chal_count_in == CCW'(CHALLENGE_BYTES)) begin
               emit             = 1'b1;
               result.kind      = mdp_pkg::KIND_CHALLENGE;
               result.chal_code = chal_shift_in;
               awaiting_in      = 1'b0;
               chal_count_in    = '0;
            end
         end else if (rx_byte == mdp_pkg::STATUS_SOX) begin
            in_sysex_in     = 1'b1;
            byte_count_in   = '0;
            seen_family_in  = '0;
            seen_command_in = '0;
         end else if (rx_byte == mdp_pkg::STATUS_EOX) begin
            if (in_sysex_ff) begin
               emit                = 1'b1;
               result.kind         = mdp_pkg::KIND_SYSEX_END;
               result.sysex_length = count_wide[8:0];
               result.is_query     = query_hit;
               in_sysex_in         = 1'b0;
               byte_count_in       = '0;
               running_in          = '0;
               if (query_hit) begin
                  awaiting_in   = 1'b1;
                  chal_count_in = '0;
                  chal_shift_in = '0;
               end
            end
         end else if (in_sysex_in) begin
            emit = 1'b1;
            if (byte_count_ff < BCW'(SYSEX_MAX)) begin
               if (byte_count_ff == BCW'(3)) begin
                  seen_family_in = rx_byte[6:0];
               end else if (byte_count_ff == BCW'(4)) begin
                  seen_command_in = rx_byte[6:0];
               end
               byte_count_in      = byte_count_ff + BCW'(1);
               result.kind        = mdp_pkg::KIND_SYSEX_DATA;
               result.data_one    = rx_byte[6:0];
               result.sysex_index = count_wide[7:0];
            end else begin
               result.kind         = mdp_pkg::KIND_ABORT;
               result.sysex_length = count_wide[8:0];
               in_sysex_in         = 1'b0;
               byte_count_in       = '0;
            end
         end else if (rx_byte[7]) begin
            running_in    = rx_byte;
            byte_count_in = '0;
         end else if (running_ff != 8'd0) begin
            result.channel  = running_ff[3:0];
            result.data_one = rx_byte[6:0];
            case (running_ff[7:4])
               mdp_pkg::CMD_NOTE_OFF:  result.kind = mdp_pkg::KIND_NOTE_OFF;
               mdp_pkg::CMD_NOTE_ON:   result.kind = mdp_pkg::KIND_NOTE_ON;
               mdp_pkg::CMD_CONTROL:   result.kind = mdp_pkg::KIND_CONTROL;
               mdp_pkg::CMD_PROGRAM:   result.kind = mdp_pkg::KIND_PROGRAM;
               mdp_pkg::CMD_PRESSURE:  result.kind = mdp_pkg::KIND_PRESSURE;
               mdp_pkg::CMD_BEND:      result.kind = mdp_pkg::KIND_BEND;
               default:                result.kind = mdp_pkg::KIND_ABORT;
            endcase
            if (result.kind == mdp_pkg::KIND_ABORT) begin
               // unknown command: drop running status
               result        = '0;
               running_in    = '0;
               byte_count_in = '0;
            end else if (result.kind == mdp_pkg::KIND_PROGRAM
                         || result.kind == mdp_pkg::KIND_PRESSURE) begin
               emit          = 1'b1;
               byte_count_in = '0;
            end else if (byte_count_ff == '0) begin
               result        = '0;
               held_in       = rx_byte[6:0];
               byte_count_in = BCW'(1);
            end else begin
               emit            = 1'b1;
               byte_count_in   = '0;
               result.data_one = held_ff;
               result.data_two = rx_byte[6:0];
               if (result.kind == mdp_pkg::KIND_BEND) begin
                  result.bend_value = {rx_byte[6:0], held_ff};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sysex_ff     <= 1'b0;
         byte_count_ff   <= '0;
         running_ff      <= '0;
         held_ff         <= '0;
         seen_family_ff  <= '0;
         seen_command_ff <= '0;
         awaiting_ff     <= 1'b0;
         chal_count_ff   <= '0;
         chal_shift_ff   <= '0;
      end else if (step) begin
         in_sysex_ff     <= in_sysex_in;
         byte_count_ff   <= byte_count_in;
         running_ff      <= running_in;
         held_ff         <= held_in;
         seen_family_ff  <= seen_family_in;
         seen_command_ff <= seen_command_in;
         awaiting_ff     <= awaiting_in;
         chal_count_ff   <= chal_count_in;
         chal_shift_ff   <= chal_shift_in;
      end
   end

   a_chal_count_range: assert property (@(posedge clock) disable iff (reset)
      chal_count_ff < CCW'(CHALLENGE_BYTES))
      else $error("challenge count out of range");

   a_byte_count_range: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= BCW'(SYSEX_MAX))
      else $error("byte count beyond SysEx limit");

   a_running_is_status: assert property (@(posedge clock) disable iff (reset)
      running_ff != 8'd0 |-> running_ff[7])
      else $error("running status holds a data byte");

   a_query_arms: assert property (@(posedge clock) disable iff (reset)
      step && emit && result.kind == mdp_pkg::KIND_SYSEX_END && result.is_query
      |=> awaiting_ff && chal_count_ff == '0)
      else $error("connection query did not arm capture");

endmodule

// ===== hdl/midi_stream_parser_with_handshake_core.sv =====
// Top level: request register, parser, result register and config registers.
// Depends on mdp_pkg and mdp_parse.
//
// MIDI byte stream parser. Takes one received byte per request and returns
// zero or one result: channel messages with running status, SysEx data
// bytes with their index, SysEx end or abort, and a seven-byte challenge
// captured after a connection query. Throughput is one byte per cycle
// while the result register is not held full; a byte that yields a result
// passes the request register, then the result register, before it shows
// on rsp_, and a held result can stall it in the request register. Bytes
// F8 and above and bytes that only update state produce nothing. req_tready
// drops only while a request is held because the result register is full
// and rsp_tready is low. The user must write config registers through csr_
// only while idle; the block itself does not enforce this.
module midi_stream_parser_with_handshake_core #(
   parameter int unsigned SYSEX_MAX       = 256,
   parameter int unsigned CHALLENGE_BYTES = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] rx_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [3:0] kind, [7:4] channel, [14:8] data_one, [21:15] data_two,
   // [35:22] bend_value, [43:36] sysex_index, [52:44] sysex_length,
   // [53] is_query, [102:54] chal_code, [103] zero
   output logic [mdp_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        csr_we,
   input  logic [0:0]                  csr_index,
   input  logic [mdp_pkg::CSR_W-1:0]   csr_wdata
);

   logic                req_valid_ff;
   logic [7:0]          req_byte_ff;
   logic                rsp_valid_ff;
   mdp_pkg::result_type rsp_data_ff;
   mdp_pkg::cfg_type    cfg_ff;
   logic                step;
   logic                emit;
   mdp_pkg::result_type result;

   assign step       = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || step;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   mdp_parse #(
      .SYSEX_MAX       (SYSEX_MAX),
      .CHALLENGE_BYTES (CHALLENGE_BYTES)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (req_byte_ff),
      .cfg     (cfg_ff),
      .emit    (emit),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (step) begin
            rsp_valid_ff <= emit;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_byte_ff <= req_tdata;
      end
      if (step && emit) begin
         rsp_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.family_id     <= mdp_pkg::FAMILY_ID_RESET;
         cfg_ff.query_command <= mdp_pkg::QUERY_COMMAND_RESET;
      end else if (csr_we) begin
         case (mdp_pkg::csr_index_type'(csr_index))
            mdp_pkg::CSR_FAMILY_ID:     cfg_ff.family_id <= csr_wdata;
            mdp_pkg::CSR_QUERY_COMMAND: cfg_ff.query_command <= csr_wdata;
            default: ;
         endcase
      end
   end

   a_held_result_stays: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff)
      else $error("pending result lost");

   a_no_step_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !step)
      else $error("parser advanced into a full result register");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.pad == 1'b0)
      else $error("result padding bit set");

endmodule
